@@ rtl/core/smd_pkg.sv @@
// Shared types, codes and field widths of the spectrogram max downscaler.
package smd_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned PIXEL_W    = 16;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CNT_REG_W  = 13;
  localparam int unsigned STEP_W     = 17;
  localparam int unsigned TEX_REG_W  = 9;
  localparam int unsigned POS_W      = 25;
  localparam int unsigned FRAC_W     = 16;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_START  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS_PER_ROW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_IMAGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT     = 3'd5;

  localparam logic [CNT_REG_W-1:0] CNT_RST  = 13'd1;
  localparam logic [STEP_W-1:0]    STEP_ONE = 17'd65536;
  localparam logic [TEX_REG_W-1:0] TEX_RST  = 9'd256;

  typedef struct packed {
    logic                valid;
    logic                store;
    logic                fetch;
    logic [STATUS_W-1:0] status;
    logic                complete;
  } req_t;

endpackage

@@ rtl/core/smd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module smd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/smd_ctrl.sv @@
// Configuration registers, position counters, address generation and clearing sweep.
module smd_ctrl #(
  parameter int unsigned TEX_DIM     = 256,
  parameter int unsigned SRC_DIM     = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [smd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               start_i,
  input  logic [smd_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [smd_pkg::PIXEL_W-1:0]        power_sample_i,
  input  logic [smd_pkg::COORD_W-1:0]        read_col_i,
  input  logic [smd_pkg::COORD_W-1:0]        read_row_i,
  output logic                               busy_o,
  output logic                               rd_en_o,
  output logic [$clog2(TEX_DIM*TEX_DIM)-1:0] rd_addr_o,
  output logic                               clr_en_o,
  output logic [$clog2(TEX_DIM*TEX_DIM)-1:0] clr_addr_o,
  output smd_pkg::req_t                      req_o,
  output logic [$clog2(TEX_DIM*TEX_DIM)-1:0] wr_addr_o,
  output logic [((SAMPLE_BITS < 16) ? SAMPLE_BITS : 16)-1:0] sample_o
);

  localparam int unsigned CELLS   = TEX_DIM * TEX_DIM;
  localparam int unsigned AW      = $clog2(CELLS);
  localparam int unsigned MW      = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int unsigned CNT_MAX = (1 << smd_pkg::CNT_REG_W) - 1;
  localparam int unsigned SRC_LIM = (SRC_DIM < CNT_MAX) ? SRC_DIM : CNT_MAX;
  localparam int unsigned CW      = $clog2(SRC_LIM + 1);
  localparam int unsigned TW      = smd_pkg::TEX_REG_W;
  localparam int unsigned PW      = smd_pkg::POS_W;

  function automatic logic [smd_pkg::CNT_REG_W-1:0] clamp_cnt(
    input logic [smd_pkg::CNT_REG_W-1:0] v
  );
    logic [smd_pkg::CNT_REG_W-1:0] r;
    if (v == '0) begin
      r = smd_pkg::CNT_REG_W'(1);
    end else if (32'(v) > 32'(SRC_DIM)) begin
      r = smd_pkg::CNT_REG_W'(SRC_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [TW-1:0] clamp_tex(input logic [TW-1:0] v);
    logic [TW-1:0] r;
    if (v == '0) begin
      r = TW'(1);
    end else if (32'(v) > 32'(TEX_DIM)) begin
      r = TW'(TEX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [smd_pkg::STEP_W-1:0] clamp_step(
    input logic [smd_pkg::STEP_W-1:0] v
  );
    return (v > smd_pkg::STEP_ONE) ? smd_pkg::STEP_ONE : v;
  endfunction

  function automatic logic [PW-1:0] sat_add(
    input logic [PW-1:0]             pos,
    input logic [smd_pkg::STEP_W-1:0] step
  );
    logic [PW:0] sum;
    sum = {1'b0, pos} + (PW+1)'(step);
    return sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
  endfunction

  logic [smd_pkg::CNT_REG_W-1:0] cols_q, rows_q;
  logic [smd_pkg::STEP_W-1:0]    col_step_q, row_step_q;
  logic [TW-1:0]                 tex_w_q, tex_h_q;

  logic [CW-1:0] col_count_q, col_count_d, row_count_q, row_count_d;
  logic [PW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic          busy_q;
  logic [AW-1:0] clr_addr_q;

  smd_pkg::req_t req_q, req_d;
  logic [AW-1:0] wr_addr_q;
  logic [MW-1:0] sample_q;

  logic [smd_pkg::CNT_REG_W-1:0] cpr, rpi;
  logic [TW-1:0]                 tw, th;
  logic [TW-1:0]                 pix_x, pix_y;
  logic                          accept, done_now, in_tex, rd_in;
  logic [CW:0]                   col_next;
  logic [31:0]                   smp_addr, rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= smd_pkg::CNT_RST;
      rows_q     <= smd_pkg::CNT_RST;
      col_step_q <= smd_pkg::STEP_ONE;
      row_step_q <= smd_pkg::STEP_ONE;
      tex_w_q    <= smd_pkg::TEX_RST;
      tex_h_q    <= smd_pkg::TEX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smd_pkg::CFG_COLS_PER_ROW:   cols_q     <= cfg_data_i[smd_pkg::CNT_REG_W-1:0];
        smd_pkg::CFG_ROWS_PER_IMAGE: rows_q     <= cfg_data_i[smd_pkg::CNT_REG_W-1:0];
        smd_pkg::CFG_COL_STEP:       col_step_q <= cfg_data_i;
        smd_pkg::CFG_ROW_STEP:       row_step_q <= cfg_data_i;
        smd_pkg::CFG_TEX_WIDTH:      tex_w_q    <= cfg_data_i[TW-1:0];
        smd_pkg::CFG_TEX_HEIGHT:     tex_h_q    <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  assign cpr      = clamp_cnt(cols_q);
  assign rpi      = clamp_cnt(rows_q);
  assign tw       = clamp_tex(tex_w_q);
  assign th       = clamp_tex(tex_h_q);
  assign accept   = start_i && !busy_q;
  assign done_now = 32'(row_count_q) >= 32'(rpi);
  assign pix_x    = pos_x_q[PW-1:smd_pkg::FRAC_W];
  assign pix_y    = pos_y_q[PW-1:smd_pkg::FRAC_W];
  assign in_tex   = (pix_x < tw) && (pix_y < th);
  assign rd_in    = (TW'(read_col_i) < tw) && (TW'(read_row_i) < th);
  assign col_next = {1'b0, col_count_q} + (CW+1)'(1);
  assign smp_addr = 32'(pix_y) * 32'(TEX_DIM) + 32'(pix_x);
  assign rd_addr  = 32'(read_row_i) * 32'(TEX_DIM) + 32'(read_col_i);

  always_comb begin
    col_count_d  = col_count_q;
    row_count_d  = row_count_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    req_d        = '0;
    req_d.valid  = accept;
    req_d.status = smd_pkg::ST_OK;
    if (accept) begin
      unique case (opcode_i)
        smd_pkg::OP_SAMPLE: begin
          if (done_now) begin
            req_d.status = smd_pkg::ST_IGNORED;
          end else begin
            req_d.store = in_tex;
            if (!in_tex) begin
              req_d.status = smd_pkg::ST_DROPPED;
            end
            if (32'(col_next) >= 32'(cpr)) begin
              col_count_d = '0;
              pos_x_d     = '0;
              row_count_d = row_count_q + CW'(1);
              pos_y_d     = sat_add(pos_y_q, clamp_step(row_step_q));
            end else begin
              col_count_d = col_next[CW-1:0];
              pos_x_d     = sat_add(pos_x_q, clamp_step(col_step_q));
            end
          end
        end
        smd_pkg::OP_READ: begin
          req_d.fetch = rd_in;
        end
        smd_pkg::OP_START: begin
          col_count_d = '0;
          row_count_d = '0;
          pos_x_d     = '0;
          pos_y_d     = '0;
        end
        default: ;
      endcase
    end
    req_d.complete = 32'(row_count_d) >= 32'(rpi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      busy_q      <= 1'b1;
      clr_addr_q  <= '0;
      req_q       <= '0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      req_q       <= req_d;
      if (accept && (opcode_i == smd_pkg::OP_START)) begin
        busy_q     <= 1'b1;
        clr_addr_q <= '0;
      end else if (busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(CELLS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= smp_addr[AW-1:0];
    sample_q  <= power_sample_i[MW-1:0];
  end

  assign busy_o     = busy_q;
  assign rd_en_o    = accept;
  assign rd_addr_o  = (opcode_i == smd_pkg::OP_READ) ? rd_addr[AW-1:0] : smp_addr[AW-1:0];
  assign clr_en_o   = busy_q;
  assign clr_addr_o = clr_addr_q;
  assign req_o      = req_q;
  assign wr_addr_o  = wr_addr_q;
  assign sample_o   = sample_q;

endmodule

@@ rtl/core/smd_rmw.sv @@
// Texture store with read-modify-write maximum, write forwarding and clear port.
module smd_rmw #(
  parameter int unsigned TEX_DIM     = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [$clog2(TEX_DIM*TEX_DIM)-1:0] rd_addr_i,
  input  logic                               clr_en_i,
  input  logic [$clog2(TEX_DIM*TEX_DIM)-1:0] clr_addr_i,
  input  smd_pkg::req_t                      req_i,
  input  logic [$clog2(TEX_DIM*TEX_DIM)-1:0] wr_addr_i,
  input  logic [((SAMPLE_BITS < 16) ? SAMPLE_BITS : 16)-1:0] sample_i,
  output logic [smd_pkg::PIXEL_W-1:0]        pixel_o
);

  localparam int unsigned CELLS = TEX_DIM * TEX_DIM;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned MW    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

  logic [MW-1:0] rdata, cur, max_val, ram_wdata;
  logic [AW-1:0] ram_waddr;
  logic          store, ram_we;
  logic          fwd_hit_q;
  logic [MW-1:0] fwd_data_q;

  assign cur       = fwd_hit_q ? fwd_data_q : rdata;
  assign max_val   = (sample_i > cur) ? sample_i : cur;
  assign store     = req_i.valid && req_i.store;
  assign ram_we    = clr_en_i || store;
  assign ram_waddr = clr_en_i ? clr_addr_i : wr_addr_i;
  assign ram_wdata = clr_en_i ? '0 : max_val;

  smd_ram #(
    .WIDTH (MW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= store && rd_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= max_val;
  end

  assign pixel_o = (req_i.valid && req_i.fetch) ? smd_pkg::PIXEL_W'(cur) : '0;

endmodule

@@ rtl/core/spectrogram_max_downscaler_top.sv @@
// Top level of the spectrogram max downscaler.
// Each accepted item gives its result with done_o in the cycle after it is accepted.
// One item a cycle is taken while busy_o is low; the texture RAM's read-modify-write
// with forwarding between neighbouring items sets that rate.
// Reset and every start item run a clearing pass over all TEX_DIM*TEX_DIM cells of
// the texture RAM, with busy_o high; the receiver cannot stall a result.
module spectrogram_max_downscaler_top #(
  parameter int unsigned TEX_DIM     = 256,
  parameter int unsigned SRC_DIM     = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [smd_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [smd_pkg::PIXEL_W-1:0]    power_sample_i,
  input  logic [smd_pkg::COORD_W-1:0]    read_col_i,
  input  logic [smd_pkg::COORD_W-1:0]    read_row_i,
  output logic                           done_o,
  output logic [smd_pkg::PIXEL_W-1:0]    pixel_value_o,
  output logic [smd_pkg::STATUS_W-1:0]   status_o,
  output logic                           image_complete_o
);

  localparam int unsigned AW = $clog2(TEX_DIM * TEX_DIM);
  localparam int unsigned MW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

  logic          rd_en, clr_en;
  logic [AW-1:0] rd_addr, clr_addr, wr_addr;
  logic [MW-1:0] sample;
  smd_pkg::req_t req;

  smd_ctrl #(
    .TEX_DIM     (TEX_DIM),
    .SRC_DIM     (SRC_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .power_sample_i (power_sample_i),
    .read_col_i     (read_col_i),
    .read_row_i     (read_row_i),
    .busy_o         (busy_o),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .clr_en_o       (clr_en),
    .clr_addr_o     (clr_addr),
    .req_o          (req),
    .wr_addr_o      (wr_addr),
    .sample_o       (sample)
  );

  smd_rmw #(
    .TEX_DIM     (TEX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rmw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_addr),
    .req_i      (req),
    .wr_addr_i  (wr_addr),
    .sample_i   (sample),
    .pixel_o    (pixel_value_o)
  );

  assign done_o           = req.valid;
  assign status_o         = req.status;
  assign image_complete_o = req.complete;

endmodule

@@ rtl/core/smd_checker.sv @@
// Port-level assertions of the spectrogram max downscaler and their bind.
module smd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [smd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [smd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [smd_pkg::OPCODE_W-1:0]   opcode_i,
  input logic [smd_pkg::PIXEL_W-1:0]    power_sample_i,
  input logic [smd_pkg::COORD_W-1:0]    read_col_i,
  input logic [smd_pkg::COORD_W-1:0]    read_row_i,
  input logic                           done_o,
  input logic [smd_pkg::PIXEL_W-1:0]    pixel_value_o,
  input logic [smd_pkg::STATUS_W-1:0]   status_o,
  input logic                           image_complete_o
);

  logic start_item;

  assign start_item = start_i && !busy_o && (opcode_i == smd_pkg::OP_START);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start_i && !busy_o))
    else $error("Result strobe does not follow an accepted item by one cycle.");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_item |=> busy_o)
    else $error("Start item did not begin the clearing pass.");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_item |=> (done_o && pixel_value_o == '0 && status_o == smd_pkg::ST_OK
                    && !image_complete_o))
    else $error("Start item gave a wrong result.");

  a_flag_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != smd_pkg::ST_OK) |-> pixel_value_o == '0)
    else $error("Flagged sample returned a pixel value.");

  a_ignored_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == smd_pkg::ST_IGNORED) |-> image_complete_o)
    else $error("Sample ignored while the image was not complete.");

endmodule

bind spectrogram_max_downscaler_top smd_checker u_smd_checker (.*);

@@ bench/tb_spectrogram_max_downscaler_top.sv @@
// Testbench for the spectrogram max downscaler: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_spectrogram_max_downscaler_top;
  import smd_pkg::*;

  localparam int unsigned TEX_DIM     = 256;
  localparam int unsigned SRC_DIM     = 4096;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TEX_CELLS   = TEX_DIM * TEX_DIM;

  localparam logic [OPCODE_W-1:0] OP_NOP  = 2'd3;
  localparam logic [POS_W-1:0]    POS_SAT = '1;

  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;
    logic [STATUS_W-1:0] status;
    logic                complete;
  } texel_result_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  start_i        = 1'b0;
  logic [OPCODE_W-1:0]   opcode_i       = OP_SAMPLE;
  logic [PIXEL_W-1:0]    power_sample_i = '0;
  logic [COORD_W-1:0]    read_col_i     = '0;
  logic [COORD_W-1:0]    read_row_i     = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [PIXEL_W-1:0]    pixel_value_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  image_complete_o;

  // Predictor copy of the registers and the image state.
  logic [CNT_REG_W-1:0] reg_cols     = CNT_RST;
  logic [CNT_REG_W-1:0] reg_rows     = CNT_RST;
  logic [STEP_W-1:0]    reg_col_step = STEP_ONE;
  logic [STEP_W-1:0]    reg_row_step = STEP_ONE;
  logic [TEX_REG_W-1:0] reg_tex_w    = TEX_RST;
  logic [TEX_REG_W-1:0] reg_tex_h    = TEX_RST;
  logic [CNT_REG_W-1:0] frame_cnt    = '0;
  logic [CNT_REG_W-1:0] bin_cnt      = '0;
  logic [POS_W-1:0]     x_acc        = '0;
  logic [POS_W-1:0]     y_acc        = '0;
  logic [PIXEL_W-1:0]   texel_max [TEX_CELLS];
  bit                   texel_seen [TEX_CELLS];

  texel_result_t texel_results_due[$];
  int unsigned   mismatch_count  = 0;
  bit            sender_may_idle = 1'b1;

  spectrogram_max_downscaler_top #(
    .TEX_DIM     (TEX_DIM),
    .SRC_DIM     (SRC_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .power_sample_i   (power_sample_i),
    .read_col_i       (read_col_i),
    .read_row_i       (read_row_i),
    .done_o           (done_o),
    .pixel_value_o    (pixel_value_o),
    .status_o         (status_o),
    .image_complete_o (image_complete_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] acc,
                                               input int unsigned step);
    int unsigned sum;
    sum = 32'(acc) + step;
    return (sum > 32'(POS_SAT)) ? POS_SAT : sum[POS_W-1:0];
  endfunction

  function automatic bit image_done();
    return bin_cnt >= clamp_u(reg_rows, 1, SRC_DIM);
  endfunction

  function automatic texel_result_t fold_item(input logic [OPCODE_W-1:0] op,
                                              input logic [PIXEL_W-1:0] power,
                                              input logic [COORD_W-1:0] col,
                                              input logic [COORD_W-1:0] row);
    texel_result_t res;
    int unsigned tw, th, cpr, x, y, idx;
    res = '0;
    tw  = clamp_u(reg_tex_w, 1, TEX_DIM);
    th  = clamp_u(reg_tex_h, 1, TEX_DIM);
    case (op)
      OP_START: begin
        frame_cnt = '0;
        bin_cnt   = '0;
        x_acc     = '0;
        y_acc     = '0;
        foreach (texel_seen[i]) texel_seen[i] = 1'b0;
      end
      OP_SAMPLE: begin
        if (image_done()) begin
          res.status = ST_IGNORED;
        end else begin
          x   = 32'(x_acc >> FRAC_W);
          y   = 32'(y_acc >> FRAC_W);
          cpr = clamp_u(reg_cols, 1, SRC_DIM);
          if (x < tw && y < th) begin
            idx = y * TEX_DIM + x;
            if (!texel_seen[idx] || power > texel_max[idx]) texel_max[idx] = power;
            texel_seen[idx] = 1'b1;
          end else begin
            res.status = ST_DROPPED;
          end
          x_acc     = sat_pos(x_acc, clamp_u(reg_col_step, 0, STEP_ONE));
          frame_cnt = frame_cnt + 1'b1;
          if (frame_cnt >= cpr) begin
            frame_cnt = '0;
            x_acc     = '0;
            bin_cnt   = bin_cnt + 1'b1;
            y_acc     = sat_pos(y_acc, clamp_u(reg_row_step, 0, STEP_ONE));
          end
        end
      end
      OP_READ: begin
        if (col < tw && row < th) begin
          idx = row * TEX_DIM + col;
          if (texel_seen[idx]) res.pixel = texel_max[idx];
        end
      end
      default: begin
      end
    endcase
    res.complete = image_done();
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int unsigned legal_lo,
                                                           input int unsigned legal_hi,
                                                           input int unsigned typ_lo,
                                                           input int unsigned typ_hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'(legal_hi);
      3: return CFG_DATA_W'(legal_lo);
      default: return CFG_DATA_W'($urandom_range(typ_lo, typ_hi));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_COLS_PER_ROW:   reg_cols     = data[CNT_REG_W-1:0];
      CFG_ROWS_PER_IMAGE: reg_rows     = data[CNT_REG_W-1:0];
      CFG_COL_STEP:       reg_col_step = data[STEP_W-1:0];
      CFG_ROW_STEP:       reg_row_step = data[STEP_W-1:0];
      CFG_TEX_WIDTH:      reg_tex_w    = data[TEX_REG_W-1:0];
      CFG_TEX_HEIGHT:     reg_tex_h    = data[TEX_REG_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_registers(input logic [CFG_DATA_W-1:0] cols,
                                   input logic [CFG_DATA_W-1:0] rows,
                                   input logic [CFG_DATA_W-1:0] col_step,
                                   input logic [CFG_DATA_W-1:0] row_step,
                                   input logic [CFG_DATA_W-1:0] tex_w,
                                   input logic [CFG_DATA_W-1:0] tex_h);
    write_reg(CFG_COLS_PER_ROW, cols);
    write_reg(CFG_ROWS_PER_IMAGE, rows);
    write_reg(CFG_COL_STEP, col_step);
    write_reg(CFG_ROW_STEP, row_step);
    write_reg(CFG_TEX_WIDTH, tex_w);
    write_reg(CFG_TEX_HEIGHT, tex_h);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_random_registers();
    program_registers(pick_reg_value(1, SRC_DIM, 1, 12),
                      pick_reg_value(1, SRC_DIM, 1, 10),
                      pick_reg_value(0, STEP_ONE, 0, STEP_ONE),
                      pick_reg_value(0, STEP_ONE, 0, STEP_ONE),
                      pick_reg_value(1, TEX_DIM, 1, 8),
                      pick_reg_value(1, TEX_DIM, 1, 8));
  endtask

  // Leaves start_i high after acceptance so that a following item goes straight on.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [PIXEL_W-1:0] power,
                           input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    while (sender_may_idle && $urandom_range(0, 99) < 19) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    opcode_i       <= op;
    power_sample_i <= power;
    read_col_i     <= col;
    read_row_i     <= row;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    texel_results_due.push_back(fold_item(op, power, col, row));
  endtask

  task automatic wait_texels_drained();
    start_i <= 1'b0;
    while (texel_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_mixed_item(input int unsigned read_pct, input int unsigned noop_pct);
    int unsigned roll, near_w, near_h;
    logic [PIXEL_W-1:0] power;
    logic [COORD_W-1:0] col, row;
    roll   = $urandom_range(0, 99);
    near_w = clamp_u(reg_tex_w, 1, 8);
    near_h = clamp_u(reg_tex_h, 1, 8);
    power  = PIXEL_W'($urandom);
    case ($urandom_range(0, 7))
      0: power = '0;
      1: power = '1;
      default: begin
      end
    endcase
    col = COORD_W'($urandom);
    row = COORD_W'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      col = COORD_W'($urandom_range(0, near_w));
      row = COORD_W'($urandom_range(0, near_h));
    end
    if (roll < read_pct) begin
      send_item(OP_READ, power, col, row);
    end else if (roll < read_pct + noop_pct) begin
      send_item(OP_NOP, power, col, row);
    end else begin
      send_item(OP_SAMPLE, power, col, row);
    end
  endtask

  task automatic test_reset_state();
    send_item(OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(OP_SAMPLE, 16'h0000, 8'h00, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(OP_NOP, 16'hA5A5, 8'h5A, 8'hA5);
  endtask

  // A one-cell texture with a flat row step: every other sample falls outside it.
  task automatic test_register_clamps();
    wait_texels_drained();
    program_registers(17'd2, 17'd3, 17'h1FFFF, 17'd0, 17'h1FE00, 17'd0);
    send_item(OP_START, 16'h5555, 8'hAA, 8'h55);
    send_item(OP_SAMPLE, 16'h1234, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(OP_SAMPLE, 16'h0000, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 16'h8001, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 16'hFFFE, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 16'h0001, 8'h00, 8'h00);
    send_item(OP_SAMPLE, 16'hFFFF, 8'h00, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h00, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h01, 8'h00);
    send_item(OP_READ, 16'h0000, 8'hFF, 8'hFF);
    send_item(OP_NOP, 16'hFFFF, 8'hFF, 8'hFF);
  endtask

  // Registers are changed half way through each image as well as before its start item.
  task automatic test_random_images();
    repeat (4) begin
      wait_texels_drained();
      program_random_registers();
      send_item(OP_START, PIXEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      repeat (45) send_mixed_item(20, 6);
      wait_texels_drained();
      program_random_registers();
      repeat (45) send_mixed_item(20, 6);
    end
  endtask

  // Over five hundred full steps in one row drive the column accumulator into saturation.
  task automatic test_position_overflow();
    wait_texels_drained();
    sender_may_idle = 1'b0;
    program_registers(17'd516, 17'd1, STEP_ONE, STEP_ONE, CFG_DATA_W'(TEX_RST),
                      CFG_DATA_W'(TEX_RST));
    send_item(OP_START, PIXEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    while (!image_done()) send_mixed_item(5, 1);
    repeat (3) send_mixed_item(5, 1);
    sender_may_idle = 1'b1;
  endtask

  always @(posedge clk_i) begin
    texel_result_t want;
    if (rst_ni && done_o) begin
      if (texel_results_due.size() == 0) begin
        $display("%0t: result with none expected: pixel %h status %0d complete %0b",
                 $time, pixel_value_o, status_o, image_complete_o);
        mismatch_count++;
      end else begin
        want = texel_results_due.pop_front();
        if (pixel_value_o !== want.pixel) begin
          $display("%0t: pixel_value expected %h actual %h", $time, want.pixel, pixel_value_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (image_complete_o !== want.complete) begin
          $display("%0t: image_complete expected %0b actual %0b",
                   $time, want.complete, image_complete_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_register_clamps();
    test_random_images();
    test_position_overflow();
    start_i <= 1'b0;
    waited = 0;
    while (texel_results_due.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (texel_results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, texel_results_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/smd_pkg.sv
rtl/core/smd_ram.sv
rtl/core/smd_ctrl.sv
rtl/core/smd_rmw.sv
rtl/core/spectrogram_max_downscaler_top.sv
rtl/core/smd_checker.sv
bench/tb_spectrogram_max_downscaler_top.sv
